// ----- rtl/fac_pkg.sv -----
package fac_pkg;

  // Arithmetic widths of the culling datapath.
  localparam int COORD_BITS = 24;
  localparam int ENTRY_BITS = 32;

  // Fixed widths of the transaction fields.
  localparam int IN_ROW_W   = 32;
  localparam int IN_COORD_W = 24;
  localparam int PLANE_W    = 3;
  localparam int ROW_IDX_W  = 2;
  localparam int NUM_COLS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;

  // A corner keeps the low COORD_BITS of its field, never more than the field holds.
  localparam int CORNER_W = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  // Sum or difference of two entries.
  localparam int COEF_W   = ENTRY_BITS + 1;
  localparam int PROD_W   = COEF_W + CORNER_W;
  // Three products plus the offset term.
  localparam int SUM_W    = PROD_W + 2;
  localparam int EXT_W    = (ENTRY_BITS > IN_ROW_W) ? ENTRY_BITS : IN_ROW_W;

  localparam logic [PLANE_W-1:0]   NO_FAIL = PLANE_W'(NUM_PLANES);
  localparam logic [ROW_IDX_W-1:0] ROW3    = ROW_IDX_W'(3);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } fac_op_t;

  typedef logic signed [ENTRY_BITS-1:0] entry_t;
  typedef logic signed [CORNER_W-1:0]   corner_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef struct packed {
    fac_op_t                      operation;
    logic [ROW_IDX_W-1:0]         row_index;
    logic signed [IN_ROW_W-1:0]   row_c0;
    logic signed [IN_ROW_W-1:0]   row_c1;
    logic signed [IN_ROW_W-1:0]   row_c2;
    logic signed [IN_ROW_W-1:0]   row_c3;
    logic signed [IN_COORD_W-1:0] box_min_x;
    logic signed [IN_COORD_W-1:0] box_min_y;
    logic signed [IN_COORD_W-1:0] box_min_z;
    logic signed [IN_COORD_W-1:0] box_max_x;
    logic signed [IN_COORD_W-1:0] box_max_y;
    logic signed [IN_COORD_W-1:0] box_max_z;
  } fac_in_t;

  typedef struct packed {
    logic               is_test_result;
    logic               visible;
    logic [PLANE_W-1:0] failing_plane;
  } fac_out_t;

  // Transaction as it travels down the row of plane cells.
  typedef struct packed {
    fac_op_t                     op;
    logic [ROW_IDX_W-1:0]        row_idx;
    entry_t [NUM_COLS-1:0]       row;
    corner_t [NUM_AXES-1:0]      lo;
    corner_t [NUM_AXES-1:0]      hi;
    logic [PLANE_W-1:0]          fail;
  } fac_item_t;

  // Sign-extend a 32-bit element, then wrap it to the stored entry width.
  function automatic entry_t to_entry(input logic signed [IN_ROW_W-1:0] v);
    logic signed [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[ENTRY_BITS-1:0];
  endfunction

  function automatic corner_t to_corner(input logic [IN_COORD_W-1:0] f);
    return f[CORNER_W-1:0];
  endfunction

endpackage

// ----- rtl/fac_cell.sv -----
// One clip plane. The cell keeps its own copy of row 3 and of its source row,
// plus the plane coefficients formed from them, and updates them when a row
// load passes through, so every transaction sees the matrix as of its order.
module fac_cell
  import fac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PLANE_W-1:0] plane_id,
  input  logic               in_valid,
  output logic               in_ready,
  input  fac_item_t          in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fac_item_t          out_item
);

  entry_t r3_r   [NUM_COLS];
  entry_t rs_r   [NUM_COLS];
  coef_t  coef_r [NUM_COLS];
  entry_t r3_nxt [NUM_COLS];
  entry_t rs_nxt [NUM_COLS];
  coef_t  coef_nxt [NUM_COLS];

  logic      va_r;
  fac_item_t item_a_r;
  prod_t     prod_a_r [NUM_AXES];
  coef_t     d_a_r;
  logic      vb_r;
  fac_item_t item_b_r;

  logic                 en_a;
  logic                 en_b;
  logic                 take;
  logic                 load_hit;
  logic [ROW_IDX_W-1:0] src_idx;
  logic                 minus;
  corner_t              corner_sel [NUM_AXES];
  prod_t                prod_nxt   [NUM_AXES];
  sum_t                 sum_b;
  fac_item_t            item_b_nxt;

  always_comb begin
    src_idx  = plane_id[ROW_IDX_W:1];
    minus    = plane_id[0];
    en_b     = !vb_r || out_ready;
    en_a     = !va_r || en_b;
    in_ready = en_a;
    take     = in_valid && en_a;
    load_hit = take && (in_item.op == OP_LOAD);

    for (int c = 0; c < NUM_COLS; c++) begin
      r3_nxt[c] = (load_hit && in_item.row_idx == ROW3)    ? in_item.row[c] : r3_r[c];
      rs_nxt[c] = (load_hit && in_item.row_idx == src_idx) ? in_item.row[c] : rs_r[c];
      coef_nxt[c] = minus ? (COEF_W'(r3_nxt[c]) - COEF_W'(rs_nxt[c]))
                          : (COEF_W'(r3_nxt[c]) + COEF_W'(rs_nxt[c]));
    end

    // The normal's sign picks the corner that lies farthest along it.
    for (int k = 0; k < NUM_AXES; k++) begin
      corner_sel[k] = coef_r[k][COEF_W-1] ? in_item.lo[k] : in_item.hi[k];
      prod_nxt[k]   = coef_r[k] * corner_sel[k];
    end

    sum_b = SUM_W'(prod_a_r[0]) + SUM_W'(prod_a_r[1]) + SUM_W'(prod_a_r[2])
          + SUM_W'(d_a_r);

    item_b_nxt = item_a_r;
    if (item_a_r.op == OP_TEST && item_a_r.fail == NO_FAIL && sum_b[SUM_W-1]) begin
      item_b_nxt.fail = plane_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      for (int c = 0; c < NUM_COLS; c++) begin
        r3_r[c]   <= '0;
        rs_r[c]   <= '0;
        coef_r[c] <= '0;
      end
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      for (int c = 0; c < NUM_COLS; c++) begin
        r3_r[c]   <= r3_nxt[c];
        rs_r[c]   <= rs_nxt[c];
        coef_r[c] <= coef_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_a_r <= in_item;
      d_a_r    <= coef_r[NUM_COLS-1];
      for (int k = 0; k < NUM_AXES; k++) begin
        prod_a_r[k] <= prod_nxt[k];
      end
    end
    if (en_b && va_r) begin
      item_b_r <= item_b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_item  = item_b_r;

endmodule

// ----- rtl/frustum_aabb_cull_core.sv -----
// Frustum culling core for axis-aligned boxes. A load transaction writes one
// row of the 4x4 view-projection matrix (signed Q16.16) and is acknowledged
// with a result whose is_test_result is 0; a test transaction gives a box with
// integer corners and returns visible plus the first clip plane (left, right,
// bottom, top, near, far as 0 to 5, or 6 when none) for which the box lies
// entirely on the outside. The core takes one transaction per clock cycle,
// unless the output side stalls, in any mix of loads and tests and returns
// results in order. A result passes through the row of six plane cells, each
// with a multiply stage and an accumulate stage, and then the output register:
// 13 registers in all, the first of which is loaded by the edge that accepts
// its transaction. A loaded row is seen by every test accepted after it and
// by none before it.
module frustum_aabb_cull_core
  import fac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fac_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fac_out_t out_data
);

  // Handshake chain between the cells; index 0 is the core input.
  logic      ch_valid [NUM_PLANES+1];
  logic      ch_ready [NUM_PLANES+1];
  fac_item_t ch_item  [NUM_PLANES+1];

  logic     out_valid_r;
  fac_out_t out_data_r;
  fac_out_t out_data_nxt;
  logic     en_out;

  // Convert the incoming transaction once into the internal form: entries
  // wrapped to the stored width, corners trimmed to the coordinate width.
  always_comb begin
    ch_item[0].op      = in_data.operation;
    ch_item[0].row_idx = in_data.row_index;
    ch_item[0].row[0]  = to_entry(in_data.row_c0);
    ch_item[0].row[1]  = to_entry(in_data.row_c1);
    ch_item[0].row[2]  = to_entry(in_data.row_c2);
    ch_item[0].row[3]  = to_entry(in_data.row_c3);
    ch_item[0].lo[0]   = to_corner(in_data.box_min_x);
    ch_item[0].lo[1]   = to_corner(in_data.box_min_y);
    ch_item[0].lo[2]   = to_corner(in_data.box_min_z);
    ch_item[0].hi[0]   = to_corner(in_data.box_max_x);
    ch_item[0].hi[1]   = to_corner(in_data.box_max_y);
    ch_item[0].hi[2]   = to_corner(in_data.box_max_z);
    // A test starts with no failing plane; a load acknowledgement reports zero.
    ch_item[0].fail    = (in_data.operation == OP_TEST) ? NO_FAIL : '0;
  end

  assign ch_valid[0] = in_valid;
  assign in_ready    = ch_ready[0];

  // Each cell tests one plane and passes the transaction on to the next.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fac_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .plane_id  (PLANE_W'(p)),
      .in_valid  (ch_valid[p]),
      .in_ready  (ch_ready[p]),
      .in_item   (ch_item[p]),
      .out_valid (ch_valid[p+1]),
      .out_ready (ch_ready[p+1]),
      .out_item  (ch_item[p+1])
    );
  end

  // The output register takes a result from the last cell whenever it is empty
  // or its result is being taken; while a finished result waits, the last cell is held.
  always_comb begin
    en_out                       = !out_valid_r || out_ready;
    ch_ready[NUM_PLANES]         = en_out;
    out_data_nxt.is_test_result  = (ch_item[NUM_PLANES].op == OP_TEST);
    out_data_nxt.visible         = (ch_item[NUM_PLANES].op == OP_TEST) &&
                                   (ch_item[NUM_PLANES].fail == NO_FAIL);
    out_data_nxt.failing_plane   = ch_item[NUM_PLANES].fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= ch_valid[NUM_PLANES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && ch_valid[NUM_PLANES]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/fac_checker.sv -----
// Port-level checks on the culling core's results.
module fac_checker
  import fac_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input fac_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input fac_out_t out_data
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A load acknowledgement carries zero verdict fields.
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_test_result |->
      !out_data.visible && out_data.failing_plane == '0)
    else $error("load acknowledgement with nonzero verdict");

  // A box answer is visible exactly when no plane failed.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_test_result |->
      out_data.visible == (out_data.failing_plane == NO_FAIL) &&
      out_data.failing_plane <= NO_FAIL)
    else $error("box verdict inconsistent with failing plane");

endmodule

bind frustum_aabb_cull_core fac_checker u_fac_checker (.*);
